// File: rtl/perfect_number_test_top_macros.svh
// Assertion helpers used by the checker of the perfect number tester.
`ifndef PERFECT_NUMBER_TEST_TOP_MACROS_SVH
`define PERFECT_NUMBER_TEST_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define PNT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define PNT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pnt_pkg.sv
`default_nettype none

package pnt_pkg;

  localparam int unsigned VALUE_WIDTH = 16;

  localparam int unsigned CAND_W   = 16;
  localparam int unsigned TESTED_W = 16;
  localparam int unsigned SUM_W    = 19;
  localparam int unsigned SUM_MAX  = 524287;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - TESTED_W - SUM_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic init_div;
    logic div_step;
    logic acc;
    logic load_out;
  } pnt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } pnt_stat_t;

endpackage

`default_nettype wire

// File: rtl/pnt_ctrl.sv
`default_nettype none

module pnt_ctrl #(
  parameter int unsigned VALUE_WIDTH = pnt_pkg::VALUE_WIDTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pnt_pkg::pnt_cmd_t      cmd_o,
  input  pnt_pkg::pnt_stat_t     stat_i
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(VALUE_WIDTH - 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StAcc   = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.scan_done) begin
          state_d = StFin;
        end else begin
          cmd_o.init_div = 1'b1;
          cnt_d          = '0;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntLast) begin
          state_d = StAcc;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d   = StCheck;
      end
      StFin: begin
        // The previous word must have left the output register first.
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pnt_datapath.sv
`default_nettype none

module pnt_datapath #(
  parameter int unsigned VALUE_WIDTH = pnt_pkg::VALUE_WIDTH
) (
  input  wire logic                          clk_i,
  input  pnt_pkg::pnt_cmd_t                  cmd_i,
  output pnt_pkg::pnt_stat_t                 stat_o,
  input  wire logic [pnt_pkg::CAND_W-1:0]    candidate_i,
  output logic      [pnt_pkg::TESTED_W-1:0]  tested_value_o,
  output logic      [pnt_pkg::SUM_W-1:0]     divisor_sum_o,
  output logic                               is_perfect_o
);

  localparam int unsigned Vw = VALUE_WIDTH;
  localparam int unsigned Sw = VALUE_WIDTH + 3;
  localparam int unsigned Cw = (Sw > pnt_pkg::SUM_W) ? Sw : pnt_pkg::SUM_W;

  logic [Vw-1:0] n_q, d_q, rem_q, sh_q;
  logic [Sw-1:0] sum_q;
  logic [Vw:0]   trial;
  logic [Vw:0]   trial_sub;
  logic          trial_ge;
  logic [Cw-1:0] sum_ext;
  logic [pnt_pkg::SUM_W-1:0] sum_sat;

  logic [pnt_pkg::TESTED_W-1:0] tested_q;
  logic [pnt_pkg::SUM_W-1:0]    sum_out_q;
  logic                         perf_q;

  // One restoring step of n mod d: bring in the next bit of n, subtract if it fits.
  assign trial     = {rem_q, sh_q[Vw-1]};
  assign trial_ge  = (trial >= {1'b0, d_q});
  assign trial_sub = trial - {1'b0, d_q};

  assign stat_o.scan_done = (d_q >= n_q);

  assign sum_ext = Cw'(sum_q);
  assign sum_sat = (sum_ext > Cw'(pnt_pkg::SUM_MAX)) ? pnt_pkg::SUM_W'(pnt_pkg::SUM_MAX)
                                                     : pnt_pkg::SUM_W'(sum_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      n_q   <= Vw'(candidate_i);
      d_q   <= Vw'(2);
      sum_q <= Sw'(1);
    end
    if (cmd_i.init_div) begin
      rem_q <= '0;
      sh_q  <= n_q;
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? Vw'(trial_sub) : Vw'(trial);
      sh_q  <= sh_q << 1;
    end
    if (cmd_i.acc) begin
      if (rem_q == '0) begin
        sum_q <= sum_q + Sw'(d_q);
      end
      d_q <= d_q + Vw'(1);
    end
    if (cmd_i.load_out) begin
      tested_q  <= pnt_pkg::TESTED_W'(n_q);
      sum_out_q <= sum_sat;
      perf_q    <= (n_q >= Vw'(2)) && (sum_q == Sw'(n_q));
    end
  end

  assign tested_value_o = tested_q;
  assign divisor_sum_o  = sum_out_q;
  assign is_perfect_o   = perf_q;

endmodule

`default_nettype wire

// File: rtl/perfect_number_test_top.sv
// Aliquot-sum perfect number tester: trial division by every d from 2 to n-1.
// Throughput is one candidate at a time.
// Each trial runs a bit-serial remainder unit.
// The next candidate is taken while a finished result waits in the output register.
// Reset (rst_ni, asynchronous, active low) clears the controller and the output valid.
`default_nettype none

module perfect_number_test_top #(
  parameter int unsigned VALUE_WIDTH = pnt_pkg::VALUE_WIDTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [pnt_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // [15:0] candidate
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic      [pnt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,  // [15:0] tested_value,
                                                                    // [34:16] divisor_sum
  output logic                                     m_axis_tuser_o   // [0] is_perfect
);

  pnt_pkg::pnt_cmd_t  cmd;
  pnt_pkg::pnt_stat_t stat;

  logic [pnt_pkg::TESTED_W-1:0] tested_value;
  logic [pnt_pkg::SUM_W-1:0]    divisor_sum;

  pnt_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  pnt_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .candidate_i    (s_axis_tdata_i[pnt_pkg::CAND_W-1:0]),
    .tested_value_o (tested_value),
    .divisor_sum_o  (divisor_sum),
    .is_perfect_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{pnt_pkg::OUT_PAD_W{1'b0}}, divisor_sum, tested_value};

endmodule

`default_nettype wire

// File: rtl/pnt_checker.sv
`default_nettype none

`include "perfect_number_test_top_macros.svh"

module pnt_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid_i,
  input wire logic                                s_axis_tready_o,
  input wire logic                                m_axis_tvalid_o,
  input wire logic                                m_axis_tready_i,
  input wire logic [pnt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  input wire logic                                m_axis_tuser_o
);

  logic in_word;
  logic [pnt_pkg::TESTED_W-1:0] tested;
  logic [pnt_pkg::SUM_W-1:0]    dsum;

  assign in_word = s_axis_tvalid_i && s_axis_tready_o;
  assign tested  = m_axis_tdata_o[pnt_pkg::TESTED_W-1:0];
  assign dsum    = m_axis_tdata_o[pnt_pkg::TESTED_W +: pnt_pkg::SUM_W];

  // A held output word keeps its contents until it is taken.
  `PNT_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                  m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
                  "output word changed while stalled")

  // Only one candidate is worked on at a time.
  `PNT_ASSERT_NXT(a_busy_after_accept, in_word, !s_axis_tready_o,
                  "input taken again right after a candidate")

  // A perfect number equals its reported sum.
  `PNT_ASSERT_IMP(a_perfect_sum, m_axis_tvalid_o && m_axis_tuser_o,
                  dsum == pnt_pkg::SUM_W'(tested),
                  "perfect flag set with sum unequal to value")

  // Nothing below two is flagged perfect.
  `PNT_ASSERT_IMP(a_perfect_min, m_axis_tvalid_o && m_axis_tuser_o,
                  tested >= pnt_pkg::TESTED_W'(2),
                  "perfect flag set on a value below two")

endmodule

bind perfect_number_test_top pnt_checker u_pnt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// File: bench/tb_perfect_number_test_top.sv
module tb_perfect_number_test_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [pnt_pkg::TESTED_W-1:0] tested;
    logic [pnt_pkg::SUM_W-1:0]    sum;
    logic                         perfect;
  } aliquot_result_t;

  // Keeps the aliquot results still owed by the block, oldest first.
  class aliquot_scoreboard;
    aliquot_result_t owed[$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     perfects_seen;

    function new();
      mismatches    = 0;
      checked       = 0;
      perfects_seen = 0;
    endfunction

    // Divisors are collected in pairs (d, n/d) up to the square root.
    function bit [31:0] aliquot_total(bit [31:0] n);
      bit [31:0] total;
      bit [31:0] d;
      total = 1;
      if (n < 2) begin
        return total;
      end
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) begin
          total += d;
          if (n / d != d) begin
            total += n / d;
          end
        end
      end
      return total;
    endfunction

    function void note_candidate(logic [pnt_pkg::CAND_W-1:0] cand);
      aliquot_result_t          r;
      bit [31:0]                total;
      bit [pnt_pkg::CAND_W-1:0] n;
      n = cand & pnt_pkg::CAND_W'((64'd1 << pnt_pkg::VALUE_WIDTH) - 64'd1);
      total = aliquot_total(32'(n));
      r.tested  = n[pnt_pkg::TESTED_W-1:0];
      r.sum     = (total > pnt_pkg::SUM_MAX) ? pnt_pkg::SUM_W'(pnt_pkg::SUM_MAX)
                                             : total[pnt_pkg::SUM_W-1:0];
      r.perfect = (n >= 2) && (total == 32'(n));
      owed.push_back(r);
    endfunction

    function void check_result(logic [pnt_pkg::TESTED_W-1:0] tested,
                               logic [pnt_pkg::SUM_W-1:0] sum, logic perfect);
      aliquot_result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected word: value %0d sum %0d perfect %0b",
                   tested, sum, perfect);
        end
        return;
      end
      want = owed.pop_front();
      checked++;
      if (perfect === 1'b1) begin
        perfects_seen++;
      end
      if (tested !== want.tested || sum !== want.sum || perfect !== want.perfect) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: value exp %0d got %0d, sum exp %0d got %0d, perfect exp %0b got %0b",
                   want.tested, tested, want.sum, sum, want.perfect, perfect);
        end
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [pnt_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [pnt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tuser_o;

  aliquot_scoreboard sb;
  int unsigned       src_idle_pct = 10;
  int unsigned       sink_idle_pct = 53;
  int unsigned       words_sent = 0;

  perfect_number_test_top #(
    .VALUE_WIDTH(pnt_pkg::VALUE_WIDTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Inputs and outputs are sampled as they stood at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      sb.note_candidate(s_axis_tdata_i[pnt_pkg::CAND_W-1:0]);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o[pnt_pkg::TESTED_W-1:0],
                      m_axis_tdata_o[pnt_pkg::TESTED_W +: pnt_pkg::SUM_W],
                      m_axis_tuser_o);
    end
  end

  task automatic send_candidate(input logic [pnt_pkg::CAND_W-1:0] cand);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= cand;
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
    words_sent++;
  endtask

  // Mostly small candidates, since the block's time grows with the value.
  function automatic logic [pnt_pkg::CAND_W-1:0] pick_candidate();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(2))
        0:       return pnt_pkg::CAND_W'(6);
        1:       return pnt_pkg::CAND_W'(28);
        default: return pnt_pkg::CAND_W'(496);
      endcase
    end else if (r < 13) begin
      return pnt_pkg::CAND_W'($urandom_range(1));
    end else if (r < 85) begin
      return pnt_pkg::CAND_W'($urandom_range(255, 2));
    end else if (r < 97) begin
      return pnt_pkg::CAND_W'($urandom_range(1023, 256));
    end
    return pnt_pkg::CAND_W'($urandom_range(2047, 1024));
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      send_candidate(pick_candidate());
    end
  endtask

  initial begin
    logic [pnt_pkg::CAND_W-1:0] directed[$];
    sb = new();
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd12, 16'd16, 16'd28,
                 16'd97, 16'd255, 16'd256, 16'd496, 16'd945, 16'd1024, 16'd8128,
                 16'd65535};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      send_candidate(directed[k]);
    end
    send_random(34);
    src_idle_pct  = 53;
    sink_idle_pct = 10;
    send_random(33);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_random(33);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    // Anything arriving now has no expectation and counts as a failure.
    repeat (100) @(posedge clk_i);

    $display("Tested %0d candidates, %0d results checked, %0d of them perfect.",
             words_sent, sb.checked, sb.perfects_seen);
    $display("Covered zero, one, primes, all perfect numbers up to 8128 and the full-scale value.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Timeout: results still outstanding.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
